// File: design/slkt_pkg.sv
package slkt_pkg;

  // Fixed field widths
  localparam int ACTION_W = 3;
  localparam int KEY_W    = 32;
  localparam int ID_W     = 31;
  localparam int IDX_W    = 7;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;

  // Default number of entries in one leaf
  localparam int DEF_CAPACITY = 128;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_LOCATE   = 3'd1,
    ACT_READ     = 3'd2,
    ACT_SET_NEXT = 3'd3,
    ACT_GET_NEXT = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_GREATER   = 3'd1,
    ST_PAST_END  = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // One stored entry
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         page;
    logic [ID_W-1:0]         slot;
  } entry_t;

  // Input beat
  typedef struct packed {
    action_t                 action;
    logic signed [KEY_W-1:0] search_key;
    logic [ID_W-1:0]         record_page;
    logic [ID_W-1:0]         record_slot;
    logic [IDX_W-1:0]        entry_index;
    logic [ID_W-1:0]         sibling_page;
  } item_t;

  // Result beat
  typedef struct packed {
    status_t                 status;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] key_out;
    logic [ID_W-1:0]         page_out;
    logic [ID_W-1:0]         slot_out;
    logic [POS_W-1:0]        entry_count;
  } result_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic                    cmp_en;
    logic                    ins_en;
    logic signed [KEY_W-1:0] cmp_key;
    logic [IDX_W-1:0]        cmp_idx;
    entry_t                  new_entry;
  } cell_ctrl_t;

endpackage

// File: design/slkt_in_if.sv
interface slkt_in_if;
  import slkt_pkg::*;

  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: design/slkt_out_if.sv
interface slkt_out_if;
  import slkt_pkg::*;

  logic    valid;
  logic    ready;
  result_t res;

  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface

// File: design/slkt_cell.sv
module slkt_cell #(
  parameter int CAPACITY = slkt_pkg::DEF_CAPACITY,
  parameter int INDEX    = 0
) (
  input  logic                                   clk,
  input  slkt_pkg::cell_ctrl_t                   ctrl,
  input  logic [$clog2(CAPACITY+1)-1:0]          count,
  input  slkt_pkg::entry_t                       left_entry,
  input  logic                                   left_lt,
  output slkt_pkg::entry_t                       entry_o,
  output logic                                   lt_o,
  output logic                                   eq_o,
  output logic                                   bnd_o,
  output slkt_pkg::entry_t                       rd_o
);
  import slkt_pkg::*;

  localparam int CW = $clog2(CAPACITY+1);

  entry_t entry_r;
  logic   lt_r;
  logic   eq_r;
  logic   hit_r;
  logic   used;

  assign used = CW'(INDEX) < count;

  // Compare flags, captured when a beat is accepted
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt_r  <= used && (entry_r.key < ctrl.cmp_key);
      eq_r  <= used && (entry_r.key == ctrl.cmp_key);
      hit_r <= used && (32'(ctrl.cmp_idx) == INDEX);
    end
  end

  // Insert: cells at or past the slot take the new entry or the left one
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && !lt_r && (CW'(INDEX) <= count)) begin
      entry_r <= left_lt ? ctrl.new_entry : left_entry;
    end
  end

  assign entry_o = entry_r;
  assign lt_o    = lt_r;
  assign eq_o    = eq_r;
  // first used cell not below the key
  assign bnd_o   = left_lt && !lt_r && used;
  assign rd_o    = hit_r ? entry_r : '0;

endmodule

// File: design/sorted_leaf_key_table.sv
// An accepted beat is held in the operand register; its result goes to the output
// register once that is free. One item at a time: each cell compares its key in the
// accept cycle; position encode, read select and the one-step row shift follow in S_EXEC.
// The output register lets the next beat in while a result still waits.
// Reset (rst_n low, synchronous): entry count cleared, next leaf pointer set to all ones,
// no result pending; stored entries stay undefined until written.
module sorted_leaf_key_table #(
  parameter int CAPACITY = slkt_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst_n,
  slkt_in_if.sink       in_ch,
  slkt_out_if.source    out_ch
);
  import slkt_pkg::*;

  localparam int CW = $clog2(CAPACITY+1);

  state_t             state_r, state_nxt;
  item_t              op_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [ID_W-1:0]    next_leaf_r, next_leaf_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r, res_nxt;
  cell_ctrl_t         ctrl;
  logic               advance;
  logic               accept;

  entry_t             cell_entry [CAPACITY];
  entry_t             cell_rd    [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] cell_bnd;

  logic               eq_any;
  logic               bnd_any;
  logic [CW-1:0]      pos_enc;
  logic [CW-1:0]      pos;
  entry_t             rd_data;

  assign accept  = in_ch.valid && in_ch.ready;
  assign advance = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  // Broadcast to the cell row
  always_comb begin
    ctrl.cmp_en         = accept;
    ctrl.cmp_key        = in_ch.item.search_key;
    ctrl.cmp_idx        = in_ch.item.entry_index;
    ctrl.ins_en         = advance && (op_r.action == ACT_INSERT) &&
                          (count_r != CW'(CAPACITY));
    ctrl.new_entry.key  = op_r.search_key;
    ctrl.new_entry.page = op_r.record_page;
    ctrl.new_entry.slot = op_r.record_slot;
  end

  // Row of cells, each fed by its left neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry;
    logic   left_lt;
    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_lt    = 1'b1;
    end else begin : g_link
      assign left_entry = cell_entry[i-1];
      assign left_lt    = cell_lt[i-1];
    end
    slkt_cell #(.CAPACITY(CAPACITY), .INDEX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .left_entry (left_entry),
      .left_lt    (left_lt),
      .entry_o    (cell_entry[i]),
      .lt_o       (cell_lt[i]),
      .eq_o       (cell_eq[i]),
      .bnd_o      (cell_bnd[i]),
      .rd_o       (cell_rd[i])
    );
  end

  // Encode boundary position and merge read data
  always_comb begin
    pos_enc = '0;
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_bnd[i]) pos_enc = pos_enc | CW'(i);
      rd_data = rd_data | cell_rd[i];
    end
    eq_any  = |cell_eq;
    bnd_any = |cell_bnd;
    pos     = bnd_any ? pos_enc : count_r;
  end

  // At most one cell hits a read; the flag is derived from the held entry index and the count
  logic [CAPACITY-1:0] cell_hit;
  for (genvar j = 0; j < CAPACITY; j++) begin : g_hit
    assign cell_hit[j] = (32'(op_r.entry_index) == j) && (CW'(j) < count_r);
  end

  // Next state and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    next_leaf_nxt = next_leaf_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (advance) begin
          state_nxt   = S_IDLE;
          res_nxt     = '0;
          res_nxt.status = ST_OK;
          case (op_r.action)
            ACT_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                res_nxt.status = ST_FULL;
              end else begin
                res_nxt.position = POS_W'(pos);
                count_nxt        = count_r + 1'b1;
              end
            end
            ACT_LOCATE: begin
              res_nxt.position = POS_W'(pos);
              if (eq_any)       res_nxt.status = ST_OK;
              else if (bnd_any) res_nxt.status = ST_GREATER;
              else              res_nxt.status = ST_PAST_END;
            end
            ACT_READ: begin
              if (|cell_hit) begin
                res_nxt.key_out  = rd_data.key;
                res_nxt.page_out = rd_data.page;
                res_nxt.slot_out = rd_data.slot;
              end else begin
                res_nxt.status = ST_BAD_INDEX;
              end
            end
            ACT_SET_NEXT: begin
              next_leaf_nxt = op_r.sibling_page;
            end
            ACT_GET_NEXT: begin
              res_nxt.page_out = next_leaf_r;
            end
            default: begin
              res_nxt.status = ST_BAD_INDEX;
            end
          endcase
          res_nxt.entry_count = POS_W'(count_nxt);
          out_valid_nxt       = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      next_leaf_r <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_leaf_r <= next_leaf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) op_r <= in_ch.item;
    res_r <= res_nxt;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.res   = res_r;

endmodule

// File: design/slkt_checker.sv
module slkt_checker #(
  parameter int CAPACITY = slkt_pkg::DEF_CAPACITY
) (
  input logic        clk,
  input logic        rst_n,
  slkt_in_if.sink    in_ch,
  slkt_out_if.source out_ch
);
  import slkt_pkg::*;

  // A result held back stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result beat dropped while stalled");

  // One item at a time: no beat taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while previous item in progress");

  // Full status only with a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.res.status == ST_FULL |->
      out_ch.res.entry_count == POS_W'(CAPACITY) && out_ch.res.position == '0)
    else $error("full status with table not full");

  // Past end points one beyond the last entry
  a_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.res.status == ST_PAST_END |->
      out_ch.res.position == out_ch.res.entry_count)
    else $error("past-end position differs from entry count");

endmodule

bind sorted_leaf_key_table slkt_checker #(.CAPACITY(CAPACITY)) u_slkt_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import slkt_pkg::*;

  localparam int RAND_ITEMS = 1250;
  localparam int ACT_CODES  = 1 << ACTION_W;
  localparam int TAIL_BEATS = 100;
  localparam int DRAIN_CYC  = 8;

  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [ID_W-1:0]         ID_MAX  = {ID_W{1'b1}};

  logic clk;
  logic rst_n;

  slkt_in_if  in_if ();
  slkt_out_if out_if ();

  sorted_leaf_key_table DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // clock: 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the leaf node
  logic signed [KEY_W-1:0] leaf_key  [DEF_CAPACITY];
  logic [ID_W-1:0]         leaf_page [DEF_CAPACITY];
  logic [ID_W-1:0]         leaf_slot [DEF_CAPACITY];
  int                      leaf_used;
  logic [KEY_W-1:0]        leaf_next;

  item_t   queued_actions [$];
  result_t awaited_results [$];
  result_t want_res;
  int      mismatches;
  logic    in_taken;

  // stimulus bookkeeping: keys sent for insert, rough fill level
  logic signed [KEY_W-1:0] sent_keys [$];
  int                      sent_fill;

  // pacing state for the two sides
  int src_gap, src_quiet, snk_gap, snk_quiet;

  // apply one action to the shadow leaf and return its result
  function automatic result_t apply_action(input item_t it);
    result_t res;
    int      i;
    int      j;
    logic    hit;
    status_t st;
    res = '0;
    res.status = ST_OK;
    // first stored key >= search key
    i = 0;
    hit = 1'b0;
    st = ST_PAST_END;
    while (i < leaf_used && !hit) begin
      if ($signed(leaf_key[i]) == $signed(it.search_key)) begin
        st = ST_OK;
        hit = 1'b1;
      end else if ($signed(leaf_key[i]) > $signed(it.search_key)) begin
        st = ST_GREATER;
        hit = 1'b1;
      end else begin
        i++;
      end
    end
    case (it.action)
      ACT_INSERT: begin
        if (leaf_used >= DEF_CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (j = leaf_used; j > i; j--) begin
            leaf_key[j]  = leaf_key[j-1];
            leaf_page[j] = leaf_page[j-1];
            leaf_slot[j] = leaf_slot[j-1];
          end
          leaf_key[i]  = it.search_key;
          leaf_page[i] = it.record_page;
          leaf_slot[i] = it.record_slot;
          leaf_used++;
          res.position = POS_W'(i);
        end
      end
      ACT_LOCATE: begin
        res.status   = st;
        res.position = POS_W'(i);
      end
      ACT_READ: begin
        if (int'(it.entry_index) >= leaf_used) begin
          res.status = ST_BAD_INDEX;
        end else begin
          res.key_out  = leaf_key[it.entry_index];
          res.page_out = leaf_page[it.entry_index];
          res.slot_out = leaf_slot[it.entry_index];
        end
      end
      ACT_SET_NEXT: leaf_next = {1'b0, it.sibling_page};
      ACT_GET_NEXT: res.page_out = leaf_next[ID_W-1:0];
      default: res.status = ST_BAD_INDEX;
    endcase
    res.entry_count = POS_W'(leaf_used);
    return res;
  endfunction

  // beat with the given action, key and index; other fields random
  function automatic item_t beat_of(input action_t act, input logic signed [KEY_W-1:0] key,
                                    input logic [IDX_W-1:0] idx);
    item_t b;
    b.action       = act;
    b.search_key   = key;
    b.record_page  = ID_W'($urandom());
    b.record_slot  = ID_W'($urandom());
    b.entry_index  = idx;
    b.sibling_page = ID_W'($urandom());
    return b;
  endfunction

  // keys: extremes, a narrow band for duplicates, or anything
  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
    if (r < 4) return KEY_W'(int'($urandom_range(0, 16)) - 8);
    return KEY_W'($urandom());
  endfunction

  function automatic action_t odd_action();
    return action_t'($urandom_range(int'(ACT_GET_NEXT) + 1, ACT_CODES - 1));
  endfunction

  task automatic queue_beat(input item_t b);
    queued_actions.push_back(b);
    if (b.action == ACT_INSERT) begin
      sent_keys.push_back(b.search_key);
      if (sent_fill < DEF_CAPACITY) sent_fill++;
    end
  endtask

  task automatic fill_stimulus();
    item_t                   b;
    logic signed [KEY_W-1:0] k;
    logic [IDX_W-1:0]        idx;
    int                      r;
    // directed: empty-table cases, extremes, duplicates, every action
    queue_beat(beat_of(ACT_GET_NEXT, pick_key(), '0));
    queue_beat(beat_of(ACT_LOCATE, '0, '0));
    queue_beat(beat_of(ACT_READ, pick_key(), '0));
    for (int c = int'(ACT_GET_NEXT) + 1; c < ACT_CODES; c++)
      queue_beat(beat_of(action_t'(c), pick_key(), IDX_W'($urandom())));
    queue_beat(beat_of(ACT_INSERT, '0, '0));
    queue_beat(beat_of(ACT_LOCATE, KEY_MAX, '0));
    b = beat_of(ACT_INSERT, KEY_MAX, '0);
    b.record_page = ID_MAX;
    b.record_slot = '0;
    queue_beat(b);
    b = beat_of(ACT_INSERT, KEY_MIN, '0);
    b.record_page = '0;
    b.record_slot = ID_MAX;
    queue_beat(b);
    queue_beat(beat_of(ACT_INSERT, '0, '0));
    queue_beat(beat_of(ACT_INSERT, -1, '0));
    queue_beat(beat_of(ACT_LOCATE, '0, '0));
    queue_beat(beat_of(ACT_LOCATE, 5, '0));
    queue_beat(beat_of(ACT_LOCATE, KEY_MAX, '0));
    queue_beat(beat_of(ACT_LOCATE, KEY_MIN, '0));
    queue_beat(beat_of(ACT_READ, pick_key(), '0));
    queue_beat(beat_of(ACT_READ, pick_key(), IDX_W'(4)));
    queue_beat(beat_of(ACT_READ, pick_key(), IDX_W'(5)));
    queue_beat(beat_of(ACT_READ, pick_key(), {IDX_W{1'b1}}));
    b = beat_of(ACT_SET_NEXT, pick_key(), '0);
    b.sibling_page = '0;
    queue_beat(b);
    queue_beat(beat_of(ACT_GET_NEXT, pick_key(), '0));
    b = beat_of(ACT_SET_NEXT, pick_key(), '0);
    b.sibling_page = ID_MAX;
    queue_beat(b);
    queue_beat(beat_of(ACT_GET_NEXT, pick_key(), '0));

    // random: the table fills gradually, then full inserts keep coming
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        queue_beat(beat_of(ACT_INSERT, pick_key(), IDX_W'($urandom())));
      end else if (r < 50) begin
        if (sent_keys.size() > 0 && $urandom_range(0, 1)) begin
          k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
          case ($urandom_range(0, 3))
            0: k = k + 1;
            1: k = k - 1;
            default: ;
          endcase
        end else begin
          k = pick_key();
        end
        queue_beat(beat_of(ACT_LOCATE, k, IDX_W'($urandom())));
      end else if (r < 78) begin
        if (sent_fill > 0 && $urandom_range(0, 3) != 0)
          idx = IDX_W'($urandom_range(0, sent_fill - 1));
        else
          idx = IDX_W'($urandom());
        queue_beat(beat_of(ACT_READ, pick_key(), idx));
      end else if (r < 85) begin
        queue_beat(beat_of(ACT_SET_NEXT, pick_key(), IDX_W'($urandom())));
      end else if (r < 93) begin
        queue_beat(beat_of(ACT_GET_NEXT, pick_key(), IDX_W'($urandom())));
      end else begin
        queue_beat(beat_of(odd_action(), pick_key(), IDX_W'($urandom())));
      end
    end
  endtask

  task automatic report(input string field, input logic [KEY_W-1:0] want,
                        input logic [KEY_W-1:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  // driver: new input beat at the falling edge, with random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_if.valid && !in_taken) begin
        // beat still waiting for ready
      end else if (src_gap > 0) begin
        in_if.valid <= 1'b0;
        src_gap--;
      end else if (queued_actions.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        if (src_quiet > 0) src_quiet--;
        if (src_quiet == 0 && queued_actions.size() > TAIL_BEATS &&
            $urandom_range(0, 99) < 10) begin
          in_if.valid <= 1'b0;
          src_gap = $urandom_range(1, 18) - 1;
        end else begin
          if (src_quiet == 0 && $urandom_range(0, 99) < 3) src_quiet = $urandom_range(20, 80);
          in_if.item  <= queued_actions.pop_front();
          in_if.valid <= 1'b1;
        end
      end
    end
  end

  // result side: ready with random stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (snk_gap > 0) begin
        out_if.ready <= 1'b0;
        snk_gap--;
      end else begin
        if (snk_quiet > 0) snk_quiet--;
        if (snk_quiet == 0 && queued_actions.size() > TAIL_BEATS &&
            $urandom_range(0, 99) < 10) begin
          out_if.ready <= 1'b0;
          snk_gap = $urandom_range(1, 18) - 1;
        end else begin
          if (snk_quiet == 0 && $urandom_range(0, 99) < 3) snk_quiet = $urandom_range(20, 80);
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  // monitor: predict on each input beat, check each result beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_if.valid && in_if.ready;
      if (in_taken) awaited_results.push_back(apply_action(in_if.item));
      if (out_if.valid && out_if.ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected, actual 0x%0h", $time, out_if.res);
        end else begin
          want_res = awaited_results.pop_front();
          if (out_if.res.status !== want_res.status)
            report("status", KEY_W'(want_res.status), KEY_W'(out_if.res.status));
          if (out_if.res.position !== want_res.position)
            report("position", KEY_W'(want_res.position), KEY_W'(out_if.res.position));
          if (out_if.res.key_out !== want_res.key_out)
            report("key_out", want_res.key_out, out_if.res.key_out);
          if (out_if.res.page_out !== want_res.page_out)
            report("page_out", KEY_W'(want_res.page_out), KEY_W'(out_if.res.page_out));
          if (out_if.res.slot_out !== want_res.slot_out)
            report("slot_out", KEY_W'(want_res.slot_out), KEY_W'(out_if.res.slot_out));
          if (out_if.res.entry_count !== want_res.entry_count)
            report("entry_count", KEY_W'(want_res.entry_count),
                   KEY_W'(out_if.res.entry_count));
        end
      end
    end
  end

  // reset, stimulus and end of run
  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.item   = '0;
    out_if.ready = 1'b0;
    in_taken     = 1'b0;
    mismatches   = 0;
    sent_fill    = 0;
    src_gap      = 0;
    src_quiet    = 0;
    snk_gap      = 0;
    snk_quiet    = 0;
    leaf_used    = 0;
    leaf_next    = '1;
    fill_stimulus();
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    while (queued_actions.size() != 0 || in_if.valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
